FILE: src/vlrrp_pkg.sv
// ----------------------------------------------------------------------------
// Velocity-layer round-robin picker: shared types and constants
// Item codes, status codes, table entry layout, controller states and the
// velocity-to-gain conversion.
// ----------------------------------------------------------------------------
package vlrrp_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_NOTE_ON = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_CLEARED  = 3'd2,
    ST_PICKED   = 3'd3,
    ST_NOMATCH  = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] vel_lo;
    logic [6:0] vel_hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int CTR_W   = 32;

  typedef struct packed {
    status_t     status;
    logic [5:0]  index;
    logic [15:0] gain;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CNT_SCAN  = 5'b00010,
    S_MOD       = 5'b00100,
    S_PICK_SCAN = 5'b01000,
    S_FINISH    = 5'b10000
  } state_t;

  // round(v * 32768 / 127) with ties up. Since 32768 = 127 * 258 + 2, the
  // quotient is v * 258 plus floor((2v + 63) / 127), which is 0, 1 or 2.
  function automatic logic [15:0] gain_of(input logic [6:0] v);
    logic [8:0]  t;
    logic [15:0] base;
    t    = 9'({v, 1'b0}) + 9'd63;
    base = {1'b0, v, 8'b0} + {8'b0, v, 1'b0};
    if (t >= 9'd254) begin
      gain_of = base + 16'd2;
    end else if (t >= 9'd127) begin
      gain_of = base + 16'd1;
    end else begin
      gain_of = base;
    end
  endfunction

endpackage

FILE: src/vlrrp_if.sv
// ----------------------------------------------------------------------------
// Velocity-layer round-robin picker: channel interfaces
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface vlrrp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] note;
  logic [6:0] velocity;
  logic [6:0] vel_low;
  logic [6:0] vel_high;

  modport source (output valid, output mode, output note, output velocity,
                  output vel_low, output vel_high, input ready);
  modport sink   (input valid, input mode, input note, input velocity,
                  input vel_low, input vel_high, output ready);
endinterface

interface vlrrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  sample_index;
  logic [15:0] gain_q15;

  modport source (output valid, output status, output sample_index,
                  output gain_q15, input ready);
  modport sink   (input valid, input status, input sample_index,
                  input gain_q15, output ready);
endinterface

FILE: src/vlrrp_ram.sv
// ----------------------------------------------------------------------------
// Velocity-layer round-robin picker: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vlrrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/vlrrp_mod_unit.sv
// ----------------------------------------------------------------------------
// Velocity-layer round-robin picker: modulo unit
// Restoring division of a 32-bit counter by the match count, one bit per
// cycle; gives the remainder and raises done when it finishes.
// ----------------------------------------------------------------------------
module vlrrp_mod_unit #(
  parameter int DIV_W = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vlrrp_pkg::CTR_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          remainder
);

  localparam int STEP_W = $clog2(vlrrp_pkg::CTR_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [vlrrp_pkg::CTR_W-1:0] shift_r, shift_nxt;
  logic [DIV_W-1:0]            div_r, div_nxt;
  logic [DIV_W-1:0]            rem_r, rem_nxt;
  logic [DIV_W:0]              trial;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    trial     = {rem_r, shift_r[vlrrp_pkg::CTR_W-1]};
    if (start) begin
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      shift_nxt = dividend;
      div_nxt   = divisor;
      rem_nxt   = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = DIV_W'(trial);
      end
      shift_nxt = {shift_r[vlrrp_pkg::CTR_W-2:0], 1'b0};
      step_nxt  = step_r + 1'b1;
      if (step_r == STEP_W'(vlrrp_pkg::CTR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r  <= step_nxt;
    shift_r <= shift_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: src/velocity_layer_round_robin_picker_top.sv
// ----------------------------------------------------------------------------
// Velocity-layer round-robin picker
// Keeps a table of sample entries and picks one per note-on in round-robin
// order among the entries whose note and velocity layer match.
// ----------------------------------------------------------------------------
// Each item on in_ch appends an entry, clears the table or plays a note; every
// item gives exactly one result item on out_ch (status, sample index, gain).
// Both channels use valid/ready; one item is handled at a time.
// Append, clear, ignored and out-of-range items are answered directly: the
// result is in the output register on the cycle after the item is taken.
// A note-on reads the table RAM once per cycle in two passes (count the
// matches, then locate the chosen one), with a bit-serial modulo unit
// between them. The output register holds a result until out_ch takes it;
// a new item is taken while that result is being taken, so a stalled
// receiver halts the block without losing or repeating items.
// Reset empties the table and zeroes every round-robin counter at once
// through per-note valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module velocity_layer_round_robin_picker_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int NOTE_COUNT  = 128
) (
  input logic          clk,
  input logic          rst_n,
  vlrrp_in_if.sink     in_ch,
  vlrrp_out_if.source  out_ch
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int NOTE_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  vlrrp_pkg::state_t           state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [6:0]                  note_r, note_nxt;
  logic [6:0]                  vel_r, vel_nxt;
  logic [CNT_W-1:0]            scan_addr_r, scan_addr_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]            rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]            matches_r, matches_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic [CNT_W-1:0]            seen_r, seen_nxt;
  logic [IDX_W-1:0]            pick_idx_r, pick_idx_nxt;
  logic [vlrrp_pkg::CTR_W-1:0] ctr_r, ctr_nxt;
  logic                        ctr_cap_r, ctr_cap_nxt;
  logic [NOTE_COUNT-1:0]       ctr_valid_r, ctr_valid_nxt;
  vlrrp_pkg::result_t          res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  vlrrp_pkg::result_t          out_r, out_nxt;

  logic                          tbl_we;
  logic [IDX_W-1:0]              tbl_waddr;
  vlrrp_pkg::entry_t             tbl_wentry;
  logic [IDX_W-1:0]              tbl_raddr;
  logic [vlrrp_pkg::ENTRY_W-1:0] tbl_rdata;
  vlrrp_pkg::entry_t             rd_entry;

  logic                        ctr_we;
  logic [NOTE_W-1:0]           ctr_raddr;
  logic [vlrrp_pkg::CTR_W-1:0] ctr_wdata;
  logic [vlrrp_pkg::CTR_W-1:0] ctr_rdata;

  logic             mod_start;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;

  logic in_take;
  logic out_free;
  logic scanning;
  logic issue;
  logic scan_end;
  logic hit;

  vlrrp_ram #(
    .WIDTH (vlrrp_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wentry),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  vlrrp_ram #(
    .WIDTH (vlrrp_pkg::CTR_W),
    .DEPTH (NOTE_COUNT)
  ) u_counters (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (note_r[NOTE_W-1:0]),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  vlrrp_mod_unit #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (ctr_r),
    .divisor   (matches_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign rd_entry  = vlrrp_pkg::entry_t'(tbl_rdata);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_take   = in_ch.valid && in_ch.ready;
  assign scanning  = (state_r == vlrrp_pkg::S_CNT_SCAN) ||
                     (state_r == vlrrp_pkg::S_PICK_SCAN);
  assign issue     = scanning && (scan_addr_r < count_r);
  assign scan_end  = scanning && !issue && !rd_vld_r;
  assign hit       = rd_vld_r && (rd_entry.note == note_r) &&
                     (vel_r >= rd_entry.vel_lo) && (vel_r <= rd_entry.vel_hi);
  assign tbl_raddr = scan_addr_r[IDX_W-1:0];
  assign ctr_raddr = in_ch.note[NOTE_W-1:0];
  assign ctr_wdata = ctr_r + 1'b1;

  assign in_ch.ready         = (state_r == vlrrp_pkg::S_IDLE) && out_free;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.sample_index = out_r.index;
  assign out_ch.gain_q15     = out_r.gain;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    note_nxt      = note_r;
    vel_nxt       = vel_r;
    scan_addr_nxt = scan_addr_r;
    rd_vld_nxt    = issue;
    rd_idx_nxt    = scan_addr_r[IDX_W-1:0];
    matches_nxt   = matches_r;
    k_nxt         = k_r;
    seen_nxt      = seen_r;
    pick_idx_nxt  = pick_idx_r;
    ctr_nxt       = ctr_r;
    ctr_cap_nxt   = 1'b0;
    ctr_valid_nxt = ctr_valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    tbl_we        = 1'b0;
    tbl_waddr     = count_r[IDX_W-1:0];
    tbl_wentry    = '{note: in_ch.note, vel_lo: in_ch.vel_low, vel_hi: in_ch.vel_high};
    ctr_we        = 1'b0;
    mod_start     = 1'b0;

    if (issue) begin
      scan_addr_nxt = scan_addr_r + 1'b1;
    end
    if (ctr_cap_r) begin
      ctr_nxt = ctr_valid_r[note_r[NOTE_W-1:0]] ? ctr_rdata : '0;
    end

    case (state_r)
      vlrrp_pkg::S_IDLE: begin
        if (in_take) begin
          note_nxt      = in_ch.note;
          vel_nxt       = in_ch.velocity;
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: vlrrp_pkg::ST_IGNORED, index: '0, gain: '0};
          case (vlrrp_pkg::mode_t'(in_ch.mode))
            vlrrp_pkg::MODE_APPEND: begin
              if (count_r >= DEPTH_C) begin
                out_nxt.status = vlrrp_pkg::ST_FULL;
              end else begin
                tbl_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_nxt.status = vlrrp_pkg::ST_APPENDED;
                out_nxt.index  = 6'(count_r);
              end
            end
            vlrrp_pkg::MODE_CLEAR: begin
              count_nxt      = '0;
              out_nxt.status = vlrrp_pkg::ST_CLEARED;
            end
            vlrrp_pkg::MODE_NOTE_ON: begin
              if (in_ch.velocity == 7'd0) begin
                out_nxt.status = vlrrp_pkg::ST_IGNORED;
              end else if (32'(in_ch.note) >= 32'(NOTE_COUNT)) begin
                out_nxt.status = vlrrp_pkg::ST_NOMATCH;
              end else begin
                out_valid_nxt = out_valid_r && !out_ch.ready;
                out_nxt       = out_r;
                ctr_cap_nxt   = 1'b1;
                scan_addr_nxt = '0;
                matches_nxt   = '0;
                state_nxt     = vlrrp_pkg::S_CNT_SCAN;
              end
            end
            default: begin
              out_nxt.status = vlrrp_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      vlrrp_pkg::S_CNT_SCAN: begin
        if (hit) begin
          matches_nxt = matches_r + 1'b1;
        end
        if (scan_end) begin
          if (matches_r == '0) begin
            res_nxt   = '{status: vlrrp_pkg::ST_NOMATCH, index: '0, gain: '0};
            state_nxt = vlrrp_pkg::S_FINISH;
          end else begin
            mod_start = 1'b1;
            state_nxt = vlrrp_pkg::S_MOD;
          end
        end
      end
      vlrrp_pkg::S_MOD: begin
        if (mod_done) begin
          k_nxt         = mod_rem;
          seen_nxt      = '0;
          scan_addr_nxt = '0;
          state_nxt     = vlrrp_pkg::S_PICK_SCAN;
        end
      end
      vlrrp_pkg::S_PICK_SCAN: begin
        if (hit) begin
          if (seen_r == k_r) begin
            pick_idx_nxt = rd_idx_r;
          end
          seen_nxt = seen_r + 1'b1;
        end
        if (scan_end) begin
          ctr_we = 1'b1;
          ctr_valid_nxt[note_r[NOTE_W-1:0]] = 1'b1;
          res_nxt = '{status: vlrrp_pkg::ST_PICKED, index: 6'(pick_idx_r),
                      gain: vlrrp_pkg::gain_of(vel_r)};
          state_nxt = vlrrp_pkg::S_FINISH;
        end
      end
      vlrrp_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = vlrrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vlrrp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vlrrp_pkg::S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      ctr_cap_r   <= 1'b0;
      ctr_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ctr_cap_r   <= ctr_cap_nxt;
      ctr_valid_r <= ctr_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    note_r      <= note_nxt;
    vel_r       <= vel_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    matches_r   <= matches_nxt;
    k_r         <= k_nxt;
    seen_r      <= seen_nxt;
    pick_idx_r  <= pick_idx_nxt;
    ctr_r       <= ctr_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

endmodule
